>>> hdl/cvr_pkg.sv
// shared types, constants and arctangent table for the circular cordic pipeline
`default_nettype none

package cvr_pkg;

  localparam int unsigned DataW         = 32;
  localparam int unsigned Steps         = 32;
  localparam int unsigned StepsPerStage = 2;
  localparam int unsigned Stages        = Steps / StepsPerStage;
  localparam int unsigned StepW         = $clog2(Steps);
  localparam int unsigned StageW        = $clog2(Stages);

  localparam logic CmdRotate = 1'b0;
  localparam logic CmdVector = 1'b1;

  typedef logic signed [DataW-1:0] word_t;

  typedef struct packed {
    logic  vect;
    word_t x;
    word_t y;
    word_t z;
  } vec_t;

  // floor(atan(2^-i) * 2^16), entries below one read as zero
  function automatic word_t atan_lut(input logic [StepW-1:0] idx);
    word_t a;
    case (idx)
      StepW'(0):  a = 32'sd51471;
      StepW'(1):  a = 32'sd30385;
      StepW'(2):  a = 32'sd16054;
      StepW'(3):  a = 32'sd8149;
      StepW'(4):  a = 32'sd4090;
      StepW'(5):  a = 32'sd2047;
      StepW'(6):  a = 32'sd1023;
      StepW'(7):  a = 32'sd511;
      StepW'(8):  a = 32'sd255;
      StepW'(9):  a = 32'sd127;
      StepW'(10): a = 32'sd63;
      StepW'(11): a = 32'sd31;
      StepW'(12): a = 32'sd15;
      StepW'(13): a = 32'sd7;
      StepW'(14): a = 32'sd3;
      StepW'(15): a = 32'sd1;
      default:    a = '0;
    endcase
    return a;
  endfunction

endpackage

`default_nettype wire

>>> hdl/cvr_in_if.sv
// input channel: command and starting vector with valid/ready handshake
`default_nettype none

interface cvr_in_if;
  import cvr_pkg::*;

  logic  valid;
  logic  ready;
  logic  cmd;
  word_t x_in;
  word_t y_in;
  word_t z_in;

  modport source (output valid, output cmd, output x_in, output y_in, output z_in,
                  input ready);
  modport sink   (input valid, input cmd, input x_in, input y_in, input z_in,
                  output ready);
endinterface

`default_nettype wire

>>> hdl/cvr_out_if.sv
// output channel: final vector with valid/ready handshake
`default_nettype none

interface cvr_out_if;
  import cvr_pkg::*;

  logic  valid;
  logic  ready;
  word_t x_out;
  word_t y_out;
  word_t z_out;

  modport source (output valid, output x_out, output y_out, output z_out,
                  input ready);
  modport sink   (input valid, input x_out, input y_out, input z_out,
                  output ready);
endinterface

`default_nettype wire

>>> hdl/cvr_stage.sv
// combinational micro-rotations for one pipeline stage
`default_nettype none

module cvr_stage (
  input  cvr_pkg::vec_t                   vec_i,
  input  logic [cvr_pkg::StageW-1:0]      stage_i,
  output cvr_pkg::vec_t                   vec_o
);
  import cvr_pkg::*;

  always_comb begin
    vec_t             v;
    logic [StepW-1:0] idx;
    word_t            xs;
    word_t            ys;
    word_t            a;
    logic             pos;
    v = vec_i;
    for (int j = 0; j < StepsPerStage; j++) begin
      idx = StepW'(int'(stage_i) * StepsPerStage + j);
      xs  = v.x >>> idx;
      ys  = v.y >>> idx;
      a   = atan_lut(idx);
      // rotate anticlockwise when z is non-negative, or when y is negative in vectoring
      pos = (v.vect == CmdVector) ? v.y[DataW-1] : ~v.z[DataW-1];
      if (pos) begin
        v.x = v.x - ys;
        v.y = v.y + xs;
        v.z = v.z - a;
      end else begin
        v.x = v.x + ys;
        v.y = v.y - xs;
        v.z = v.z + a;
      end
    end
    vec_o = v;
  end

endmodule

`default_nettype wire

>>> hdl/circular_cordic_rotate_vector.sv
// Circular CORDIC, rotation and vectoring modes, 32 micro-rotations, no gain correction.
// Pipeline: 16 registered stages, two micro-rotations each. Throughput: one transaction per cycle
// while out_o.ready is high; each stage holds its item while the next is full,
// so bubbles are squeezed out and the input keeps accepting while any stage has room.
// Reset: rst_ni clears all stage valid bits asynchronously; the datapath is not reset.
`default_nettype none

module circular_cordic_rotate_vector (
  input  wire         clk_i,
  input  wire         rst_ni,
  cvr_in_if.sink      in_i,
  cvr_out_if.source   out_o
);
  import cvr_pkg::*;

  logic [Stages-1:0] valid_q;
  vec_t              data_q [Stages];
  vec_t              data_d [Stages];
  logic [Stages:0]   en;
  vec_t              in_vec;

  assign in_vec = '{vect: in_i.cmd, x: in_i.x_in, y: in_i.y_in, z: in_i.z_in};

  // a stage may load when empty or when its own item moves on
  assign en[Stages] = out_o.ready;
  for (genvar k = 0; k < Stages; k++) begin : g_en
    assign en[k] = ~valid_q[k] | en[k+1];
  end

  assign in_i.ready = en[0];

  for (genvar k = 0; k < Stages; k++) begin : g_stage
    vec_t stage_in;
    logic valid_in;

    if (k == 0) begin : g_first
      assign stage_in = in_vec;
      assign valid_in = in_i.valid;
    end else begin : g_rest
      assign stage_in = data_q[k-1];
      assign valid_in = valid_q[k-1];
    end

    cvr_stage u_stage (
      .vec_i   (stage_in),
      .stage_i (StageW'(k)),
      .vec_o   (data_d[k])
    );

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        valid_q[k] <= 1'b0;
      end else if (en[k]) begin
        valid_q[k] <= valid_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en[k] && valid_in) begin
        data_q[k] <= data_d[k];
      end
    end
  end

  assign out_o.valid = valid_q[Stages-1];
  assign out_o.x_out = data_q[Stages-1].x;
  assign out_o.y_out = data_q[Stages-1].y;
  assign out_o.z_out = data_q[Stages-1].z;

endmodule

`default_nettype wire
